// ----- rtl/jho_pkg.sv -----
// ----------------------------------------------------------------------------
// jho_pkg
// Types, widths and constants for the jet HT / overlap removal block.
// ----------------------------------------------------------------------------
package jho_pkg;

    // store and count sizes
    localparam int LARGE_DEPTH = 32;
    localparam int SMALL_MAX   = 64;
    localparam int LARGE_AW    = $clog2(LARGE_DEPTH);
    localparam int LARGE_CNT_W = $clog2(LARGE_DEPTH + 1);
    localparam int SMALL_CNT_W = $clog2(SMALL_MAX + 1);

    // field widths
    localparam int MODE_W   = 2;
    localparam int PT_W     = 16;
    localparam int ETA_W    = 14;
    localparam int PHI_W    = 13;
    localparam int AETA_W   = 13;
    localparam int DR2_W    = 26;
    localparam int CFG_W    = 26;
    localparam int CFG_IW   = 3;
    localparam int LSUM_W   = 21;
    localparam int CSUM_W   = 23;
    localparam int HT_W     = 22;
    localparam int CCNT_W   = 7;
    localparam int LCNT_W   = 6;
    localparam int STORE_W  = ETA_W + PHI_W;

    // scan datapath widths
    localparam int DETA_W   = ETA_W + 1;
    localparam int DPHI_W   = PHI_W + 1;
    localparam int SQE_W    = 28;
    localparam int SQP_W    = 24;
    localparam int DSUM_W   = SQE_W + 1;

    // azimuth wrap, 1/1024 rad
    localparam int PHI_PI     = 3217;
    localparam int PHI_TWO_PI = 6434;

    // register reset values
    localparam logic [PT_W-1:0]   LARGE_PT_MIN_RST = 16'd700;
    localparam logic [PT_W-1:0]   SMALL_PT_MIN_RST = 16'd120;
    localparam logic [AETA_W-1:0] ABS_ETA_MAX_RST  = 13'd2458;
    localparam logic [DR2_W-1:0]  DR2_MAX_RST      = 26'd671089;
    localparam logic [PT_W-1:0]   SELECT_PT_MIN_RST = 16'd720;

    typedef enum logic [MODE_W-1:0] {
        MODE_LARGE = 2'd0,
        MODE_SMALL = 2'd1,
        MODE_END   = 2'd2
    } mode_t;

    typedef enum logic [CFG_IW-1:0] {
        CFG_LARGE_PT_MIN  = 3'd0,
        CFG_SMALL_PT_MIN  = 3'd1,
        CFG_ABS_ETA_MAX   = 3'd2,
        CFG_OVERLAP_DR2   = 3'd3,
        CFG_SELECT_PT_MIN = 3'd4
    } cfg_idx_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

endpackage

// ----- rtl/jet_ht_overlap_removal.sv -----
// The result is valid the cycle after the marker.
// A passing small jet with N stored large jets (N <= 32) is scanned through the single read port
// of the eta/phi store: one stored jet is read and compared per cycle; no request is taken
// during the scan. Failing or dropped small jets, and those with no stored large jet, skip it.
// Reset (aresetn low, synchronous) clears event state, the result valid and restores the
// register defaults; the eta/phi store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// jet_ht_overlap_removal
// Per-event large-jet pt sum, small-jet HT and deltaR-cleaned combined sum.
// ----------------------------------------------------------------------------
module jet_ht_overlap_removal (
    input  logic                                aclk,
    input  logic                                aresetn,

    // configuration writes
    input  logic                                cfg_we,
    input  logic [jho_pkg::CFG_IW-1:0]          cfg_index,
    input  logic [jho_pkg::CFG_W-1:0]           cfg_wdata,

    // jet request channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [jho_pkg::MODE_W-1:0]          s_mode,
    input  logic [jho_pkg::PT_W-1:0]            s_jet_pt,
    input  logic signed [jho_pkg::ETA_W-1:0]    s_jet_eta,
    input  logic signed [jho_pkg::PHI_W-1:0]    s_jet_phi,

    // per-event result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [jho_pkg::LSUM_W-1:0]          m_large_pt_sum,
    output logic [jho_pkg::CSUM_W-1:0]          m_combined_sum,
    output logic [jho_pkg::HT_W-1:0]            m_small_ht,
    output logic [jho_pkg::CCNT_W-1:0]          m_clean_small_count,
    output logic [jho_pkg::LCNT_W-1:0]          m_large_count,
    output logic                                m_pass_two_large,
    output logic                                m_pass_three_large,
    output logic                                m_order_error
);
    import jho_pkg::*;

    localparam int LC_EXT_W = (LARGE_CNT_W > LCNT_W) ? LARGE_CNT_W : LCNT_W;
    localparam logic [LC_EXT_W-1:0] LC_SAT = LC_EXT_W'((1 << LCNT_W) - 1);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [PT_W-1:0]   large_pt_min_reg;
    logic [PT_W-1:0]   small_pt_min_reg;
    logic [AETA_W-1:0] abs_eta_max_reg;
    logic [DR2_W-1:0]  dr2_max_reg;
    logic [PT_W-1:0]   select_pt_min_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            large_pt_min_reg  <= LARGE_PT_MIN_RST;
            small_pt_min_reg  <= SMALL_PT_MIN_RST;
            abs_eta_max_reg   <= ABS_ETA_MAX_RST;
            dr2_max_reg       <= DR2_MAX_RST;
            select_pt_min_reg <= SELECT_PT_MIN_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_LARGE_PT_MIN:  large_pt_min_reg  <= cfg_wdata[PT_W-1:0];
                CFG_SMALL_PT_MIN:  small_pt_min_reg  <= cfg_wdata[PT_W-1:0];
                CFG_ABS_ETA_MAX:   abs_eta_max_reg   <= cfg_wdata[AETA_W-1:0];
                CFG_OVERLAP_DR2:   dr2_max_reg       <= cfg_wdata[DR2_W-1:0];
                CFG_SELECT_PT_MIN: select_pt_min_reg <= cfg_wdata[PT_W-1:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // large-jet eta/phi store: one write or one read per cycle, registered
    // read data. Writes only happen in idle and reads only while scanning,
    // so the two never touch the same entry in flight.
    // ------------------------------------------------------------------
    logic [STORE_W-1:0]  store_mem [LARGE_DEPTH];
    logic                store_we;
    logic [LARGE_AW-1:0] store_waddr;
    logic [STORE_W-1:0]  store_wdata;
    logic                store_re;
    logic [LARGE_AW-1:0] store_raddr;
    logic [STORE_W-1:0]  store_rdata_reg;

    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_mem[store_waddr] <= store_wdata;
        end
        if (store_re) begin
            store_rdata_reg <= store_mem[store_raddr];
        end
    end

    // ------------------------------------------------------------------
    // event and control state
    // ------------------------------------------------------------------
    state_t                 state_reg, state_next;
    logic [LARGE_CNT_W-1:0] large_cnt_reg, large_cnt_next;
    logic [SMALL_CNT_W-1:0] small_cnt_reg, small_cnt_next;
    logic [2:0]             ftp_reg, ftp_next;        // first three pass selection
    logic [LSUM_W-1:0]      large_sum_reg, large_sum_next;
    logic [HT_W-1:0]        small_ht_reg, small_ht_next;
    logic [CSUM_W-1:0]      clean_sum_reg, clean_sum_next;
    logic [CCNT_W-1:0]      clean_cnt_reg, clean_cnt_next;
    logic                   seen_small_reg, seen_small_next;
    logic                   order_reg, order_next;

    // scan control
    logic [LARGE_CNT_W-1:0] iss_idx_reg, iss_idx_next;
    logic                   p1_vld_reg, p1_vld_next;  // read data valid
    logic                   p2_vld_reg;               // deltas valid
    logic                   p3_vld_reg;               // squares valid
    logic                   hit_reg, hit_next;        // overlap found

    // held small jet for the scan (payload, no reset)
    logic [PT_W-1:0]         sj_pt_reg, sj_pt_next;
    logic signed [ETA_W-1:0] sj_eta_reg, sj_eta_next;
    logic signed [PHI_W-1:0] sj_phi_reg, sj_phi_next;

    // scan datapath (payload)
    logic signed [DETA_W-1:0] deta_reg;
    logic signed [PHI_W-1:0]  dphi_reg;
    logic [SQE_W-1:0]         sq_eta_reg;
    logic [SQP_W-1:0]         sq_phi_reg;

    // result register
    logic                   m_valid_reg, m_valid_next;
    logic [LSUM_W-1:0]      r_lsum_reg;
    logic [CSUM_W-1:0]      r_csum_reg;
    logic [HT_W-1:0]        r_ht_reg;
    logic [CCNT_W-1:0]      r_ccnt_reg;
    logic [LCNT_W-1:0]      r_lcnt_reg;
    logic                   r_two_reg, r_three_reg, r_order_reg;
    logic                   res_load;

    // ------------------------------------------------------------------
    // request decode and cuts
    // ------------------------------------------------------------------
    logic                   out_free;
    logic                   s_acc;
    logic [ETA_W-1:0]       abs_eta;
    logic                   eta_ok;
    logic                   large_room, small_room;
    logic                   scan_done;

    // saturating sums
    logic [LSUM_W:0]        lsum_add;
    logic [HT_W:0]          ht_add;
    logic [PT_W-1:0]        clean_pt;
    logic [CSUM_W:0]        csum_add;
    logic [CSUM_W-1:0]      csum_sat;
    logic [CCNT_W-1:0]      ccnt_sat;
    logic [CSUM_W:0]        comb_add;
    logic [CSUM_W-1:0]      comb_sat;
    logic [LC_EXT_W-1:0]    lc_ext;

    assign out_free = !m_valid_reg || m_ready;
    // a marker needs the result slot; jets go through while a result waits
    assign s_ready  = (state_reg == ST_IDLE) && ((s_mode != MODE_END) || out_free);
    assign s_acc    = s_valid && s_ready;

    assign abs_eta    = s_jet_eta[ETA_W-1] ? ETA_W'(-s_jet_eta) : ETA_W'(s_jet_eta);
    assign eta_ok     = abs_eta < {1'b0, abs_eta_max_reg};
    assign large_room = large_cnt_reg < LARGE_CNT_W'(LARGE_DEPTH);
    assign small_room = small_cnt_reg < SMALL_CNT_W'(SMALL_MAX);
    assign scan_done  = (iss_idx_reg == large_cnt_reg) && !p1_vld_reg && !p2_vld_reg
                        && !p3_vld_reg;

    assign lsum_add = {1'b0, large_sum_reg} + (LSUM_W + 1)'(s_jet_pt);
    assign ht_add   = {1'b0, small_ht_reg} + (HT_W + 1)'(s_jet_pt);
    assign clean_pt = (state_reg == ST_IDLE) ? s_jet_pt : sj_pt_reg;
    assign csum_add = {1'b0, clean_sum_reg} + (CSUM_W + 1)'(clean_pt);
    assign csum_sat = csum_add[CSUM_W] ? {CSUM_W{1'b1}} : csum_add[CSUM_W-1:0];
    assign ccnt_sat = (&clean_cnt_reg) ? clean_cnt_reg : clean_cnt_reg + 1'b1;
    assign comb_add = (CSUM_W + 1)'(large_sum_reg) + (CSUM_W + 1)'(clean_sum_reg);
    assign comb_sat = comb_add[CSUM_W] ? {CSUM_W{1'b1}} : comb_add[CSUM_W-1:0];
    assign lc_ext   = LC_EXT_W'(large_cnt_reg);

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next      = state_reg;
        large_cnt_next  = large_cnt_reg;
        small_cnt_next  = small_cnt_reg;
        ftp_next        = ftp_reg;
        large_sum_next  = large_sum_reg;
        small_ht_next   = small_ht_reg;
        clean_sum_next  = clean_sum_reg;
        clean_cnt_next  = clean_cnt_reg;
        seen_small_next = seen_small_reg;
        order_next      = order_reg;
        iss_idx_next    = iss_idx_reg;
        p1_vld_next     = 1'b0;
        hit_next        = hit_reg;
        sj_pt_next      = sj_pt_reg;
        sj_eta_next     = sj_eta_reg;
        sj_phi_next     = sj_phi_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        res_load        = 1'b0;
        store_we        = 1'b0;
        store_waddr     = large_cnt_reg[LARGE_AW-1:0];
        store_wdata     = {s_jet_eta, s_jet_phi};
        store_re        = 1'b0;
        store_raddr     = iss_idx_reg[LARGE_AW-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    unique case (s_mode)
                        MODE_LARGE: begin
                            if (seen_small_reg) begin
                                order_next = 1'b1;
                            end
                            if (large_room) begin
                                store_we       = 1'b1;
                                large_cnt_next = large_cnt_reg + 1'b1;
                                if (large_cnt_reg < LARGE_CNT_W'(3) &&
                                    s_jet_pt > select_pt_min_reg && eta_ok) begin
                                    ftp_next[large_cnt_reg[1:0]] = 1'b1;
                                end
                                if (s_jet_pt > large_pt_min_reg && eta_ok) begin
                                    large_sum_next = lsum_add[LSUM_W] ? {LSUM_W{1'b1}}
                                                                      : lsum_add[LSUM_W-1:0];
                                end
                            end
                        end
                        MODE_SMALL: begin
                            seen_small_next = 1'b1;
                            if (small_room) begin
                                small_cnt_next = small_cnt_reg + 1'b1;
                                if (s_jet_pt > small_pt_min_reg && eta_ok) begin
                                    small_ht_next = ht_add[HT_W] ? {HT_W{1'b1}}
                                                                 : ht_add[HT_W-1:0];
                                    if (large_cnt_reg == '0) begin
                                        // nothing stored to overlap with
                                        clean_sum_next = csum_sat;
                                        clean_cnt_next = ccnt_sat;
                                    end else begin
                                        state_next   = ST_SCAN;
                                        iss_idx_next = '0;
                                        hit_next     = 1'b0;
                                        sj_pt_next   = s_jet_pt;
                                        sj_eta_next  = s_jet_eta;
                                        sj_phi_next  = s_jet_phi;
                                    end
                                end
                            end
                        end
                        MODE_END: begin
                            res_load        = 1'b1;
                            m_valid_next    = 1'b1;
                            large_cnt_next  = '0;
                            small_cnt_next  = '0;
                            ftp_next        = '0;
                            large_sum_next  = '0;
                            small_ht_next   = '0;
                            clean_sum_next  = '0;
                            clean_cnt_next  = '0;
                            seen_small_next = 1'b0;
                            order_next      = 1'b0;
                        end
                        default: ;  // unused code, no effect
                    endcase
                end
            end
            ST_SCAN: begin
                if (iss_idx_reg != large_cnt_reg) begin
                    store_re     = 1'b1;
                    p1_vld_next  = 1'b1;
                    iss_idx_next = iss_idx_reg + 1'b1;
                end
                if (scan_done) begin
                    if (!hit_reg) begin
                        clean_sum_next = csum_sat;
                        clean_cnt_next = ccnt_sat;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // compare stage
        if (p3_vld_reg && ({1'b0, sq_eta_reg} + DSUM_W'(sq_phi_reg) <=
                           DSUM_W'(dr2_max_reg))) begin
            hit_next = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // scan pipeline: deltas with phi wrap, then squares
    // ------------------------------------------------------------------
    logic signed [ETA_W-1:0]  st_eta;
    logic signed [PHI_W-1:0]  st_phi;
    logic signed [DETA_W-1:0] deta_c;
    logic signed [DPHI_W:0]   dphi_raw;
    logic signed [DPHI_W:0]   dphi_wr;
    logic signed [2*DETA_W-1:0] sq_eta_full;
    logic signed [2*PHI_W-1:0]  sq_phi_full;

    assign st_eta   = store_rdata_reg[STORE_W-1:PHI_W];
    assign st_phi   = store_rdata_reg[PHI_W-1:0];
    assign deta_c   = DETA_W'(st_eta) - DETA_W'(sj_eta_reg);
    assign dphi_raw = (DPHI_W + 1)'(st_phi) - (DPHI_W + 1)'(sj_phi_reg);

    // one correction each way covers the full 13-bit input range
    always_comb begin
        if (dphi_raw >= (DPHI_W + 1)'(PHI_PI)) begin
            dphi_wr = dphi_raw - (DPHI_W + 1)'(PHI_TWO_PI);
        end else if (dphi_raw < -(DPHI_W + 1)'(PHI_PI)) begin
            dphi_wr = dphi_raw + (DPHI_W + 1)'(PHI_TWO_PI);
        end else begin
            dphi_wr = dphi_raw;
        end
    end

    assign sq_eta_full = deta_reg * deta_reg;
    assign sq_phi_full = dphi_reg * dphi_reg;

    always_ff @(posedge aclk) begin
        deta_reg   <= deta_c;
        dphi_reg   <= dphi_wr[PHI_W-1:0];
        sq_eta_reg <= sq_eta_full[SQE_W-1:0];
        sq_phi_reg <= sq_phi_full[SQP_W-1:0];
        sj_pt_reg  <= sj_pt_next;
        sj_eta_reg <= sj_eta_next;
        sj_phi_reg <= sj_phi_next;
    end

    // ------------------------------------------------------------------
    // state registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            large_cnt_reg  <= '0;
            small_cnt_reg  <= '0;
            ftp_reg        <= '0;
            large_sum_reg  <= '0;
            small_ht_reg   <= '0;
            clean_sum_reg  <= '0;
            clean_cnt_reg  <= '0;
            seen_small_reg <= 1'b0;
            order_reg      <= 1'b0;
            iss_idx_reg    <= '0;
            p1_vld_reg     <= 1'b0;
            p2_vld_reg     <= 1'b0;
            p3_vld_reg     <= 1'b0;
            hit_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            large_cnt_reg  <= large_cnt_next;
            small_cnt_reg  <= small_cnt_next;
            ftp_reg        <= ftp_next;
            large_sum_reg  <= large_sum_next;
            small_ht_reg   <= small_ht_next;
            clean_sum_reg  <= clean_sum_next;
            clean_cnt_reg  <= clean_cnt_next;
            seen_small_reg <= seen_small_next;
            order_reg      <= order_next;
            iss_idx_reg    <= iss_idx_next;
            p1_vld_reg     <= p1_vld_next;
            p2_vld_reg     <= p1_vld_reg;
            p3_vld_reg     <= p2_vld_reg;
            hit_reg        <= hit_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // result payload, loaded from the event state at the end marker
    always_ff @(posedge aclk) begin
        if (res_load) begin
            r_lsum_reg  <= large_sum_reg;
            r_csum_reg  <= comb_sat;
            r_ht_reg    <= small_ht_reg;
            r_ccnt_reg  <= clean_cnt_reg;
            r_lcnt_reg  <= (lc_ext > LC_SAT) ? LC_SAT[LCNT_W-1:0] : lc_ext[LCNT_W-1:0];
            r_two_reg   <= (large_cnt_reg == LARGE_CNT_W'(2)) && (&ftp_reg[1:0]) &&
                           (clean_cnt_reg >= CCNT_W'(2));
            r_three_reg <= (large_cnt_reg >= LARGE_CNT_W'(3)) && (&ftp_reg);
            r_order_reg <= order_reg;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_large_pt_sum      = r_lsum_reg;
    assign m_combined_sum      = r_csum_reg;
    assign m_small_ht          = r_ht_reg;
    assign m_clean_small_count = r_ccnt_reg;
    assign m_large_count       = r_lcnt_reg;
    assign m_pass_two_large    = r_two_reg;
    assign m_pass_three_large  = r_three_reg;
    assign m_order_error       = r_order_reg;

endmodule

// ----- bench/jet_ht_overlap_removal_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jet_ht_overlap_removal_tb
// Self-checking bench for the per-event jet HT / overlap removal block.
// Directed events, then random events under several register settings. Each per-event result
// is checked against an in-bench event model, or against the row's values for typed rows.
// ----------------------------------------------------------------------------
module jet_ht_overlap_removal_tb;
    import jho_pkg::*;

    // unused mode code, must be ignored by the block
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // wait that covers the longest busy stretch of one request: full store scan plus pipeline
    localparam int SCAN_SETTLE = 48;
    localparam int PHASE_ITEMS = 100;
    localparam int NUM_PHASES  = 6;
    localparam int HOLD_CYCLES = 500;

    typedef struct packed {
        logic [LSUM_W-1:0] large_pt_sum;
        logic [CSUM_W-1:0] combined_sum;
        logic [HT_W-1:0]   small_ht;
        logic [CCNT_W-1:0] clean_small_count;
        logic [LCNT_W-1:0] large_count;
        logic              pass_two_large;
        logic              pass_three_large;
        logic              order_error;
    } event_result_t;

    // clock / reset
    logic aclk;
    logic aresetn = 1'b0;

    // config port
    logic              cfg_we    = 1'b0;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [CFG_W-1:0]  cfg_wdata = '0;

    // request channel
    logic                    s_valid   = 1'b0;
    logic                    s_ready;
    logic [MODE_W-1:0]       s_mode    = '0;
    logic [PT_W-1:0]         s_jet_pt  = '0;
    logic signed [ETA_W-1:0] s_jet_eta = '0;
    logic signed [PHI_W-1:0] s_jet_phi = '0;

    // result channel
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [LSUM_W-1:0] m_large_pt_sum;
    logic [CSUM_W-1:0] m_combined_sum;
    logic [HT_W-1:0]   m_small_ht;
    logic [CCNT_W-1:0] m_clean_small_count;
    logic [LCNT_W-1:0] m_large_count;
    logic              m_pass_two_large;
    logic              m_pass_three_large;
    logic              m_order_error;

    jet_ht_overlap_removal uut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_mode              (s_mode),
        .s_jet_pt            (s_jet_pt),
        .s_jet_eta           (s_jet_eta),
        .s_jet_phi           (s_jet_phi),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_large_pt_sum      (m_large_pt_sum),
        .m_combined_sum      (m_combined_sum),
        .m_small_ht          (m_small_ht),
        .m_clean_small_count (m_clean_small_count),
        .m_large_count       (m_large_count),
        .m_pass_two_large    (m_pass_two_large),
        .m_pass_three_large  (m_pass_three_large),
        .m_order_error       (m_order_error)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // run limit, far above the slowest legal run
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Event model: register copies and per-event accumulators
    // ------------------------------------------------------------------
    logic [PT_W-1:0]   thr_large_pt  = LARGE_PT_MIN_RST;
    logic [PT_W-1:0]   thr_small_pt  = SMALL_PT_MIN_RST;
    logic [AETA_W-1:0] thr_abs_eta   = ABS_ETA_MAX_RST;
    logic [DR2_W-1:0]  thr_dr2       = DR2_MAX_RST;
    logic [PT_W-1:0]   thr_select_pt = SELECT_PT_MIN_RST;

    int          ev_large_eta [LARGE_DEPTH];
    int          ev_large_phi [LARGE_DEPTH];
    int unsigned ev_large_n    = 0;
    int unsigned ev_small_n    = 0;
    logic [2:0]  ev_sel_bits   = '0;
    int unsigned ev_large_sum  = 0;
    int unsigned ev_small_ht   = 0;
    int unsigned ev_clean_sum  = 0;
    int unsigned ev_clean_n    = 0;
    bit          ev_small_seen = 1'b0;
    bit          ev_order_bad  = 1'b0;

    event_result_t expected_results [$];

    // scoreboard / bookkeeping
    int error_count     = 0;
    int results_checked = 0;
    int jets_sent       = 0;
    int events_sent     = 0;
    int settings_used   = 1;

    // idle percentages per side, and the long receiver hold-off
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          hold_off_req  = 1'b0;
    bit          hold_started  = 1'b0;
    int          hold_left     = 0;

    // a small jet overlaps if any stored large jet lies within the dR^2 limit;
    // dphi wraps into [-pi, pi)
    function automatic bit near_large_jet(input int eta, input int phi);
        longint deta;
        longint dphi;
        for (int i = 0; i < ev_large_n; i++) begin
            deta = longint'(ev_large_eta[i]) - eta;
            dphi = longint'(ev_large_phi[i]) - phi;
            while (dphi >= PHI_PI) dphi -= PHI_TWO_PI;
            while (dphi < -PHI_PI) dphi += PHI_TWO_PI;
            if (deta * deta + dphi * dphi <= longint'(thr_dr2))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // advance the event model by one request; returns 1 when a result is due
    function automatic bit advance_event(input logic [MODE_W-1:0] mode,
                                         input logic [PT_W-1:0] pt,
                                         input logic signed [ETA_W-1:0] eta,
                                         input logic signed [PHI_W-1:0] phi,
                                         output event_result_t res);
        int          eta_i;
        int          eta_abs;
        bit          eta_ok;
        int unsigned total;
        res     = '0;
        eta_i   = eta;
        eta_abs = (eta_i < 0) ? -eta_i : eta_i;
        eta_ok  = eta_abs < int'(thr_abs_eta);
        case (mode)
            MODE_LARGE: begin
                // large after small flags the event, jet still counts
                if (ev_small_seen) ev_order_bad = 1'b1;
                if (ev_large_n >= LARGE_DEPTH) return 1'b0;
                ev_large_eta[ev_large_n] = eta_i;
                ev_large_phi[ev_large_n] = phi;
                if (ev_large_n < 3 && pt > thr_select_pt && eta_ok)
                    ev_sel_bits[ev_large_n] = 1'b1;
                if (pt > thr_large_pt && eta_ok) begin
                    ev_large_sum += pt;
                    if (ev_large_sum > (1 << LSUM_W) - 1) ev_large_sum = (1 << LSUM_W) - 1;
                end
                ev_large_n++;
                return 1'b0;
            end
            MODE_SMALL: begin
                ev_small_seen = 1'b1;
                if (ev_small_n >= SMALL_MAX) return 1'b0;
                ev_small_n++;
                if (pt > thr_small_pt && eta_ok) begin
                    ev_small_ht += pt;
                    if (ev_small_ht > (1 << HT_W) - 1) ev_small_ht = (1 << HT_W) - 1;
                    if (!near_large_jet(eta_i, phi)) begin
                        ev_clean_sum += pt;
                        if (ev_clean_sum > (1 << CSUM_W) - 1) ev_clean_sum = (1 << CSUM_W) - 1;
                        if (ev_clean_n < (1 << CCNT_W) - 1) ev_clean_n++;
                    end
                end
                return 1'b0;
            end
            MODE_END: begin
                total = ev_large_sum + ev_clean_sum;
                if (total > (1 << CSUM_W) - 1) total = (1 << CSUM_W) - 1;
                res.large_pt_sum      = ev_large_sum[LSUM_W-1:0];
                res.combined_sum      = total[CSUM_W-1:0];
                res.small_ht          = ev_small_ht[HT_W-1:0];
                res.clean_small_count = ev_clean_n[CCNT_W-1:0];
                res.large_count       = (ev_large_n > 63) ? 6'd63 : ev_large_n[LCNT_W-1:0];
                res.pass_two_large    = (ev_large_n == 2 && ev_sel_bits[1:0] == 2'b11 &&
                                         ev_clean_n >= 2);
                res.pass_three_large  = (ev_large_n >= 3 && ev_sel_bits == 3'b111);
                res.order_error       = ev_order_bad;
                // event state clears, settings stay
                ev_large_n    = 0;
                ev_small_n    = 0;
                ev_sel_bits   = '0;
                ev_large_sum  = 0;
                ev_small_ht   = 0;
                ev_clean_sum  = 0;
                ev_clean_n    = 0;
                ev_small_seen = 1'b0;
                ev_order_bad  = 1'b0;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Request driver. Called at a rising edge; returns at a rising edge.
    // typed: the expected result comes from the caller, not the model.
    // ------------------------------------------------------------------
    task automatic send_jet(input int mode, input int pt, input int eta, input int phi,
                            input bit typed, input event_result_t want);
        event_result_t predicted;
        s_valid   <= 1'b1;
        s_mode    <= mode[MODE_W-1:0];
        s_jet_pt  <= pt[PT_W-1:0];
        s_jet_eta <= eta[ETA_W-1:0];
        s_jet_phi <= phi[PHI_W-1:0];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (advance_event(mode[MODE_W-1:0], pt[PT_W-1:0], eta[ETA_W-1:0], phi[PHI_W-1:0],
                          predicted))
            expected_results.insert(expected_results.size(), typed ? want : predicted);
        if (mode != MODE_UNUSED) jets_sent++;
        if (mode == MODE_END) events_sent++;
        // random gap between requests
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // wait for every pending result, then let any scan in flight finish
    task automatic settle();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SCAN_SETTLE) @(posedge aclk);
    endtask

    // write all five registers back to back; block must be idle
    task automatic apply_settings(input int large_pt, input int small_pt, input int abs_eta,
                                  input int dr2, input int select_pt);
        logic [CFG_W-1:0] vals [5];
        vals[0] = large_pt[CFG_W-1:0];
        vals[1] = small_pt[CFG_W-1:0];
        vals[2] = abs_eta[CFG_W-1:0];
        vals[3] = dr2[CFG_W-1:0];
        vals[4] = select_pt[CFG_W-1:0];
        for (int i = 0; i < 5; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= i[CFG_IW-1:0];
            cfg_wdata <= vals[i];
            @(posedge aclk);
            case (cfg_idx_t'(i[CFG_IW-1:0]))
                CFG_LARGE_PT_MIN:  thr_large_pt  = vals[i][PT_W-1:0];
                CFG_SMALL_PT_MIN:  thr_small_pt  = vals[i][PT_W-1:0];
                CFG_ABS_ETA_MAX:   thr_abs_eta   = vals[i][AETA_W-1:0];
                CFG_OVERLAP_DR2:   thr_dr2       = vals[i][DR2_W-1:0];
                CFG_SELECT_PT_MIN: thr_select_pt = vals[i][PT_W-1:0];
                default: ;
            endcase
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // Random jet content
    // ------------------------------------------------------------------
    function automatic int random_pt();
        int r;
        r = $urandom_range(99);
        if (r < 5) return 0;
        if (r < 10) return 65535;
        if (r < 55) return $urandom_range(2000);
        return $urandom_range(65535);
    endfunction

    function automatic int random_eta();
        if ($urandom_range(99) < 70) return int'($urandom_range(6000)) - 3000;
        return int'($urandom_range(16382)) - 8191;
    endfunction

    function automatic int random_phi();
        return int'($urandom_range(2 * PHI_PI)) - PHI_PI;
    endfunction

    // one event: large jets, small jets (half placed near a large jet so the
    // dR cut is exercised), end marker; a few carry an ignored mode-3 request
    // or a late large jet
    task automatic send_random_event();
        int shape;
        int n_large;
        int n_small;
        int pick;
        int e;
        int p;
        bit exact;
        int l_eta [LARGE_DEPTH+4];
        int l_phi [LARGE_DEPTH+4];
        shape   = $urandom_range(99);
        n_large = (shape < 4) ? $urandom_range(LARGE_DEPTH + 2, LARGE_DEPTH - 3)
                              : $urandom_range(4);
        n_small = (shape >= 4 && shape < 8) ? $urandom_range(SMALL_MAX + 2, SMALL_MAX - 4)
                                            : $urandom_range(6);
        if ($urandom_range(99) < 5)
            send_jet(MODE_UNUSED, random_pt(), random_eta(), random_phi(), 1'b0, '0);
        for (int k = 0; k < n_large; k++) begin
            l_eta[k] = random_eta();
            l_phi[k] = random_phi();
            send_jet(MODE_LARGE, random_pt(), l_eta[k], l_phi[k], 1'b0, '0);
        end
        for (int k = 0; k < n_small; k++) begin
            if (n_large > 0 && $urandom_range(1) == 1) begin
                pick  = $urandom_range(n_large - 1);
                exact = ($urandom_range(9) == 0);
                e = l_eta[pick] + (exact ? 0 : int'($urandom_range(1400)) - 700);
                p = l_phi[pick] + (exact ? 0 : int'($urandom_range(1400)) - 700);
                if (e > 8191) e = 8191;
                if (e < -8191) e = -8191;
                if (p > PHI_PI) p -= PHI_TWO_PI;
                if (p < -PHI_PI) p += PHI_TWO_PI;
            end else begin
                e = random_eta();
                p = random_phi();
            end
            send_jet(MODE_SMALL, random_pt(), e, p, 1'b0, '0);
        end
        if ($urandom_range(99) < 8)
            send_jet(MODE_LARGE, random_pt(), random_eta(), random_phi(), 1'b0, '0);
        send_jet(MODE_END, random_pt(), random_eta(), random_phi(), 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // Result side: random ready, plus one long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_off_req && !hold_started) begin
            hold_started = 1'b1;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        event_result_t oldest;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result arrived with no event pending");
                error_count++;
            end else begin
                oldest = expected_results.pop_front();
                compare_field("large_pt_sum", oldest.large_pt_sum, m_large_pt_sum);
                compare_field("combined_sum", oldest.combined_sum, m_combined_sum);
                compare_field("small_ht", oldest.small_ht, m_small_ht);
                compare_field("clean_small_count", oldest.clean_small_count,
                              m_clean_small_count);
                compare_field("large_count", oldest.large_count, m_large_count);
                compare_field("pass_two_large", oldest.pass_two_large, m_pass_two_large);
                compare_field("pass_three_large", oldest.pass_three_large,
                              m_pass_three_large);
                compare_field("order_error", oldest.order_error, m_order_error);
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed events, under reset register values.
    // Columns: mode, pt, eta, phi, typed, then when typed the expected
    // lsum, csum, ht, clean count, large count, two-large, three-large, order.
    // ------------------------------------------------------------------
    int directed_rows [27][13] = '{
        // empty event straight after reset: all zero
        '{MODE_END,       0,     0,     0, 1, 0, 0, 0, 0, 0, 0, 0, 0},
        // extremes of pt / eta / phi; one clean small jet, one overlapped
        '{MODE_LARGE, 65535,     0,     0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{MODE_LARGE,   800,  8191, -3217, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{MODE_SMALL, 65535,     0,  3217, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{MODE_SMALL,   200, -8191,     0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{MODE_SMALL,   121,   100,     0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{MODE_END,       0,     0,     0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        // large after small: order error, nothing passes
        '{MODE_SMALL,     0,     0,     0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{MODE_LARGE,     0,     0,     0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{MODE_END,       0,     0,     0, 1, 0, 0, 0, 0, 1, 0, 0, 1},
        // azimuth wrap at +-pi, with an ignored mode-3 request inside
        '{MODE_LARGE,     0,     0,  3217, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{MODE_LARGE,     0,     0, -3217, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{MODE_SMALL,  1000,     0, -3217, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{MODE_SMALL,  1000,     0,  3216, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{MODE_SMALL,  1000,     0,     0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{MODE_UNUSED, 65535,   -1,    -1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{MODE_END,       0,     0,     0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        // three-large selection, edge of the eta cut, a fourth jet
        '{MODE_LARGE, 65535, -2457,  -100, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{MODE_LARGE,   721,  2457,  1000, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{MODE_LARGE, 65535,     0,  2000, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{MODE_LARGE,     0, -8191,     0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{MODE_END,       0,     0,     0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        // two-large selection with two clean small jets; marker payload ignored
        '{MODE_LARGE,  1000,     0,     0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{MODE_LARGE,  1000,     0,     0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{MODE_SMALL,   500,     0,  3000, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{MODE_SMALL,   500,     0, -3000, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{MODE_END,   65535, -8191, -3217, 0, 0, 0, 0, 0, 0, 0, 0, 0}
    };

    initial begin : stimulus
        int            col [13];
        event_result_t want;
        int            phase_start;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sender idles lightly, receiver heavily
        send_idle_pct = 31;
        recv_idle_pct = 88;
        foreach (directed_rows[r]) begin
            col  = directed_rows[r];
            want = '0;
            want.large_pt_sum      = col[5][LSUM_W-1:0];
            want.combined_sum      = col[6][CSUM_W-1:0];
            want.small_ht          = col[7][HT_W-1:0];
            want.clean_small_count = col[8][CCNT_W-1:0];
            want.large_count       = col[9][LCNT_W-1:0];
            want.pass_two_large    = col[10][0];
            want.pass_three_large  = col[11][0];
            want.order_error       = col[12][0];
            send_jet(col[0], col[1], col[2], col[3], col[4][0], want);
        end
        settle();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: apply_settings(LARGE_PT_MIN_RST, SMALL_PT_MIN_RST, ABS_ETA_MAX_RST,
                                  DR2_MAX_RST, SELECT_PT_MIN_RST);
                1: apply_settings(0, 0, 8191, 0, 0);
                2: apply_settings(65535, 65535, 0, 67108863, 65535);
                4: apply_settings(400, 60, 4096, 2000000, 500);
                default: apply_settings($urandom_range(1500), $urandom_range(400),
                                        $urandom_range(8191, 1500), $urandom_range(4000000),
                                        $urandom_range(1500));
            endcase
            // idle profile: 31/88, then 88/31, then none
            if (phase < 2) begin
                send_idle_pct = 31;
                recv_idle_pct = 88;
            end else if (phase < 4) begin
                send_idle_pct = 88;
                recv_idle_pct = 31;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // long receiver stall while events keep coming: block backs up
            if (phase == 4) hold_off_req = 1'b1;
            phase_start = jets_sent;
            while (jets_sent - phase_start < PHASE_ITEMS) send_random_event();
            settle();
        end

        $display("covered %0d events, %0d jet requests, %0d register settings",
                 events_sent, jets_sent, settings_used);
        $display("checked %0d results, %0d mismatches", results_checked, error_count);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/jho_pkg.sv
rtl/jet_ht_overlap_removal.sv
bench/jet_ht_overlap_removal_tb.sv
